@@ rtl/cylinder_position_supervisor_top_macros.svh @@
// Assertion macros for the cylinder position supervisor.
// Included by the top level; relies on clk and rst in the including scope.
`ifndef CYLINDER_POSITION_SUPERVISOR_TOP_MACROS_SVH
`define CYLINDER_POSITION_SUPERVISOR_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cps_pkg.sv @@
// Shared types and constants for the cylinder position supervisor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cps_pkg;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd4000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESENT_MASK  = 3'd0,
    CFG_FWD_SETTLE    = 3'd1,
    CFG_BWD_SETTLE    = 3'd2,
    CFG_FWD_TIMEOUT   = 3'd3,
    CFG_BWD_TIMEOUT   = 3'd4
  } cfg_idx_t;

  // present_mask bit positions
  localparam int PM_FWD_SENSOR = 0;
  localparam int PM_BWD_SENSOR = 1;
  localparam int PM_FWD_VALVE  = 2;
  localparam int PM_BWD_VALVE  = 3;

  typedef struct packed {
    logic [3:0]       present_mask;
    logic [CFG_W-1:0] fwd_settle_ms;
    logic [CFG_W-1:0] bwd_settle_ms;
    logic [CFG_W-1:0] fwd_timeout_ms;
    logic [CFG_W-1:0] bwd_timeout_ms;
  } cfg_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_MOVE = 1'b1
  } command_t;

  typedef struct packed {
    command_t command;
    logic     bwd_sensor;
    logic     fwd_sensor;
    logic     direction;
  } item_t;

  // fwd_valve in bit 0
  typedef struct packed {
    logic fault;
    logic done_res;
    logic actual_pos;
    logic commanded_pos;
    logic bwd_valve;
    logic fwd_valve;
  } res_t;

endpackage

@@ rtl/cps_cfg.sv @@
// Configuration register file of the cylinder position supervisor.
// Depends on cps_pkg.
`timescale 1ns / 1ps

module cps_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [cps_pkg::CFG_IDX_W-1:0] index,
  input  logic [cps_pkg::CFG_W-1:0]     data,
  output cps_pkg::cfg_t                 cfg
);
  import cps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.present_mask   <= '0;
      cfg.fwd_settle_ms  <= '0;
      cfg.bwd_settle_ms  <= '0;
      cfg.fwd_timeout_ms <= TIMEOUT_RESET;
      cfg.bwd_timeout_ms <= TIMEOUT_RESET;
    end else if (we) begin
      unique case (cfg_idx_t'(index))
        CFG_PRESENT_MASK: cfg.present_mask   <= data[3:0];
        CFG_FWD_SETTLE:   cfg.fwd_settle_ms  <= data;
        CFG_BWD_SETTLE:   cfg.bwd_settle_ms  <= data;
        CFG_FWD_TIMEOUT:  cfg.fwd_timeout_ms <= data;
        CFG_BWD_TIMEOUT:  cfg.bwd_timeout_ms <= data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/cps_ctrl.sv @@
// Supervisor state: drives, command, position latch, settle and timeout timers.
// Depends on cps_pkg; updates once per beat when upd is high.
`timescale 1ns / 1ps

module cps_ctrl #(
  parameter int TIMER_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           upd,
  input  cps_pkg::item_t item,
  input  cps_pkg::cfg_t  cfg,
  output cps_pkg::res_t  res
);
  import cps_pkg::*;

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic                  fired;
    logic [TIMER_BITS-1:0] count;
  } tmr_t;

  function automatic tmr_t on_delay(input logic [TIMER_BITS-1:0] count, input logic cond,
                                    input logic [CFG_W-1:0] delay);
    tmr_t r;
    r.fired = cond && (CW'(count) >= CW'(delay));
    if (!cond) begin
      r.count = '0;
    end else if (count == CNT_MAX) begin
      r.count = count;
    end else begin
      r.count = count + 1'b1;
    end
    return r;
  endfunction

  logic                  cmd_reg, act_reg, fwd_drive, bwd_drive, fault_reg;
  logic [TIMER_BITS-1:0] fwd_settle_count, bwd_settle_count;
  logic [TIMER_BITS-1:0] fwd_timeout_count, bwd_timeout_count;

  logic                  cmd_reg_next, act_reg_next, fwd_drive_next, bwd_drive_next;
  logic                  fault_reg_next;
  logic [TIMER_BITS-1:0] fwd_settle_count_next, bwd_settle_count_next;
  logic [TIMER_BITS-1:0] fwd_timeout_count_next, bwd_timeout_count_next;

  logic has_fs, has_bs, has_fv, has_bv;
  logic vf, vb, act_tick;
  tmr_t sf, sb, tf, tb;

  assign has_fs = cfg.present_mask[PM_FWD_SENSOR];
  assign has_bs = cfg.present_mask[PM_BWD_SENSOR];
  assign has_fv = cfg.present_mask[PM_FWD_VALVE];
  assign has_bv = cfg.present_mask[PM_BWD_VALVE];

  always_comb begin
    priority if (has_fs) vf = item.fwd_sensor;
    else if (has_bs)     vf = !item.bwd_sensor;
    else if (has_fv)     vf = fwd_drive;
    else                 vf = !bwd_drive;

    priority if (has_bs) vb = item.bwd_sensor;
    else if (has_fs)     vb = !item.fwd_sensor;
    else if (has_bv)     vb = bwd_drive;
    else                 vb = !fwd_drive;

    sf = on_delay(fwd_settle_count, vf, cfg.fwd_settle_ms);
    sb = on_delay(bwd_settle_count, vb, cfg.bwd_settle_ms);
    // backward wins a tie
    act_tick = sb.fired ? 1'b0 : (sf.fired ? 1'b1 : act_reg);
    tf = on_delay(fwd_timeout_count, cmd_reg && !act_tick, cfg.fwd_timeout_ms);
    tb = on_delay(bwd_timeout_count, !cmd_reg && act_tick, cfg.bwd_timeout_ms);

    cmd_reg_next           = cmd_reg;
    act_reg_next           = act_reg;
    fwd_drive_next         = fwd_drive;
    bwd_drive_next         = bwd_drive;
    fault_reg_next         = fault_reg;
    fwd_settle_count_next  = fwd_settle_count;
    bwd_settle_count_next  = bwd_settle_count;
    fwd_timeout_count_next = fwd_timeout_count;
    bwd_timeout_count_next = bwd_timeout_count;

    if (item.command == CMD_MOVE) begin
      cmd_reg_next = item.direction;
      if (has_fv) fwd_drive_next = item.direction;
      if (has_bv) bwd_drive_next = !item.direction;
    end else if (!has_fv && !has_bv) begin
      fwd_timeout_count_next = '0;
      bwd_timeout_count_next = '0;
    end else begin
      act_reg_next           = act_tick;
      fwd_settle_count_next  = sf.count;
      bwd_settle_count_next  = sb.count;
      fwd_timeout_count_next = tf.count;
      bwd_timeout_count_next = tb.count;
      fault_reg_next         = tf.fired || tb.fired;
    end

    res.fwd_valve     = has_fv && fwd_drive_next;
    res.bwd_valve     = has_bv && bwd_drive_next;
    res.commanded_pos = cmd_reg_next;
    res.actual_pos    = act_reg_next;
    res.done_res      = (cmd_reg_next == act_reg_next);
    res.fault         = fault_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_reg           <= 1'b0;
      act_reg           <= 1'b0;
      fwd_drive         <= 1'b0;
      bwd_drive         <= 1'b0;
      fault_reg         <= 1'b0;
      fwd_settle_count  <= '0;
      bwd_settle_count  <= '0;
      fwd_timeout_count <= '0;
      bwd_timeout_count <= '0;
    end else if (upd) begin
      cmd_reg           <= cmd_reg_next;
      act_reg           <= act_reg_next;
      fwd_drive         <= fwd_drive_next;
      bwd_drive         <= bwd_drive_next;
      fault_reg         <= fault_reg_next;
      fwd_settle_count  <= fwd_settle_count_next;
      bwd_settle_count  <= bwd_settle_count_next;
      fwd_timeout_count <= fwd_timeout_count_next;
      bwd_timeout_count <= bwd_timeout_count_next;
    end
  end

endmodule

@@ rtl/cylinder_position_supervisor_top.sv @@
// Top level of the cylinder position supervisor: input and output beat registers.
// Depends on cps_pkg, cps_cfg, cps_ctrl and the assertion macro header.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  s_tuser command, s_tdata sensors and direction
//   m_*      out        m_tvalid/m_tready  m_tdata one result per input beat
//   cfg_*    in         cfg_we             cfg_index, cfg_data
//
// One beat per cycle sustained while m_tready is high; an accepted beat passes the input
// register, the update logic and the result register before it leaves on m_*.
// Synchronous reset clears state and the valid flags of both beat registers; no clearing pass.
// A stalled output holds its result while one more input beat waits in the input register.
`timescale 1ns / 1ps

module cylinder_position_supervisor_top #(
  parameter int TIMER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // direction, fwd_sensor, bwd_sensor, zeros
  input  logic [0:0]                    s_tuser,   // command
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // fwd_valve, bwd_valve, commanded_pos,
                                                   // actual_pos, done_res, fault, zeros
  input  logic                          cfg_we,
  input  logic [cps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cps_pkg::CFG_W-1:0]     cfg_data
);
  import cps_pkg::*;

  `include "cylinder_position_supervisor_top_macros.svh"

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  res_t  res, out_res;
  logic  out_valid;
  logic  advance, upd;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign upd      = in_valid && advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res};

  cps_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  cps_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.command    <= command_t'(s_tuser[0]);
      in_item.direction  <= s_tdata[0];
      in_item.fwd_sensor <= s_tdata[1];
      in_item.bwd_sensor <= s_tdata[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_res <= res;
    end
  end

  `CPS_ASSERT(a_done_consistent,
    m_tvalid |-> (out_res.done_res == (out_res.commanded_pos == out_res.actual_pos)),
    "done_res disagrees with positions")
  `CPS_ASSERT(a_no_overrun,
    !(s_tvalid && s_tready && in_valid && out_valid && !m_tready),
    "input beat accepted with both stages stalled")
  `CPS_ASSERT(a_out_hold,
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
    "stalled result beat changed")
  `CPS_ASSERT_ALWAYS(a_reset_empty,
    $past(rst) |-> (!m_tvalid && s_tready),
    "pipeline not empty after reset")

endmodule
